// File: rtl/bnav_pkg.sv
// Shared types, codes and helper functions for the button navigation block.
// No dependencies; used by bnav_core and button_action_autorepeat.
package bnav_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned ButtonsW = 7;
  localparam int unsigned EdgeW    = 6;
  localparam int unsigned DirW     = 2;
  localparam int unsigned NumDirs  = 4;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ActionW  = 3;
  localparam int unsigned CfgIdxW  = 1;

  localparam int unsigned ConfirmBit = 4;
  localparam int unsigned BackBit    = 5;
  localparam int unsigned HomeBit    = 6;

  localparam logic [DelayW-1:0] InitialDelayReset = DelayW'(400);
  localparam logic [DelayW-1:0] RepeatPeriodReset = DelayW'(150);

  // Item kinds.
  localparam logic [KindW-1:0] KIND_BUTTON = 2'd0;
  localparam logic [KindW-1:0] KIND_MOUSE  = 2'd1;
  localparam logic [KindW-1:0] KIND_RESYNC = 2'd2;

  // Navigation actions.
  localparam logic [ActionW-1:0] ACT_NONE   = 3'd0;
  localparam logic [ActionW-1:0] ACT_UP     = 3'd1;
  localparam logic [ActionW-1:0] ACT_SELECT = 3'd5;
  localparam logic [ActionW-1:0] ACT_BACK   = 3'd6;
  localparam logic [ActionW-1:0] ACT_HOME   = 3'd7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_DELAY = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_PERIOD = 1'd1;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [ButtonsW-1:0] buttons_n;
    logic                system_home;
    logic [TimeW-1:0]    now_ms;
  } item_t;

  typedef struct packed {
    logic               has_result;
    logic [ActionW-1:0] action;
    logic               source;
  } result_t;

  typedef struct packed {
    logic [DelayW-1:0] press_delay_ms;
    logic [DelayW-1:0] repeat_period_ms;
  } cfg_t;

  // Index of the lowest set bit among the four directions.
  function automatic logic [DirW-1:0] first_dir(input logic [NumDirs-1:0] v);
    logic [DirW-1:0] idx;
    idx = '0;
    for (int i = NumDirs - 1; i >= 0; i--) begin
      if (v[i]) idx = DirW'(i);
    end
    return idx;
  endfunction

  // Index of the highest set bit among the four directions.
  function automatic logic [DirW-1:0] last_dir(input logic [NumDirs-1:0] v);
    logic [DirW-1:0] idx;
    idx = '0;
    for (int i = 0; i < NumDirs; i++) begin
      if (v[i]) idx = DirW'(i);
    end
    return idx;
  endfunction

  function automatic logic [ActionW-1:0] dir_action(input logic [DirW-1:0] d);
    return ACT_UP + ActionW'(d);
  endfunction

endpackage

// File: rtl/bnav_core.sv
// Decision logic and persistent state (edge history, repeat timer, source).
// Depends on bnav_pkg.
module bnav_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_fire,
  input  bnav_pkg::item_t  item,
  input  bnav_pkg::cfg_t   cfg,
  output bnav_pkg::result_t result
);
  import bnav_pkg::*;

  logic [EdgeW-1:0] prev_buttons_n_r, prev_buttons_n_nxt;
  logic             repeat_valid_r, repeat_valid_nxt;
  logic [DirW-1:0]  repeat_dir_r, repeat_dir_nxt;
  logic [TimeW-1:0] next_repeat_time_r, next_repeat_time_nxt;
  logic             last_source_r, last_source_nxt;

  logic [ButtonsW-1:0] down;
  logic [EdgeW-1:0]    edges;
  logic [NumDirs-1:0]  held;
  logic [NumDirs-1:0]  held_rest;
  logic [DirW-1:0]     first_held, second_held, last_held;
  logic                has_second;
  logic                match, due;
  logic [TimeW-1:0]    diff;
  logic [TimeW-1:0]    now_plus_delay, now_plus_period;
  logic [ActionW-1:0]  button_action;

  always_comb begin
    down            = ~item.buttons_n;
    edges           = down[EdgeW-1:0] & prev_buttons_n_r;
    held            = down[NumDirs-1:0];
    first_held      = first_dir(held);
    last_held       = last_dir(held);
    held_rest       = held & (held - NumDirs'(1));
    has_second      = |held_rest;
    second_held     = first_dir(held_rest);
    match           = repeat_valid_r && (repeat_dir_r == first_held);
    diff            = item.now_ms - next_repeat_time_r;
    due             = ~diff[TimeW-1];
    now_plus_delay  = item.now_ms + TimeW'(cfg.press_delay_ms);
    now_plus_period = item.now_ms + TimeW'(cfg.repeat_period_ms);

    if (edges[ConfirmBit])   button_action = ACT_SELECT;
    else if (edges[BackBit]) button_action = ACT_BACK;
    else                     button_action = ACT_NONE;
  end

  always_comb begin
    prev_buttons_n_nxt   = prev_buttons_n_r;
    repeat_valid_nxt     = repeat_valid_r;
    repeat_dir_nxt       = repeat_dir_r;
    next_repeat_time_nxt = next_repeat_time_r;
    last_source_nxt      = last_source_r;
    result.has_result    = 1'b0;
    result.action        = ACT_NONE;

    case (item.kind)
      KIND_MOUSE: begin
        last_source_nxt = 1'b0;
      end
      KIND_RESYNC: begin
        prev_buttons_n_nxt   = item.buttons_n[EdgeW-1:0];
        repeat_valid_nxt     = 1'b0;
        repeat_dir_nxt       = '0;
        next_repeat_time_nxt = '0;
      end
      KIND_BUTTON: begin
        result.has_result = 1'b1;
        if (|down[EdgeW-1:0]) last_source_nxt = 1'b1;
        if (down[HomeBit] || item.system_home) begin
          // Home wins outright and leaves edge history and repeat alone.
          last_source_nxt = 1'b1;
          result.action   = ACT_HOME;
        end else begin
          prev_buttons_n_nxt = item.buttons_n[EdgeW-1:0];
          if (|edges[NumDirs-1:0]) begin
            repeat_valid_nxt     = 1'b1;
            repeat_dir_nxt       = first_dir(edges[NumDirs-1:0]);
            next_repeat_time_nxt = now_plus_delay;
            result.action        = dir_action(first_dir(edges[NumDirs-1:0]));
          end else if (|held) begin
            if (match && due) begin
              next_repeat_time_nxt = now_plus_period;
              result.action        = dir_action(first_held);
            end else if ((cfg.press_delay_ms == '0) && (!match || has_second)) begin
              // A re-armed direction is due at once when the delay is zero.
              repeat_valid_nxt     = 1'b1;
              repeat_dir_nxt       = match ? second_held : first_held;
              next_repeat_time_nxt = now_plus_period;
              result.action        = dir_action(match ? second_held : first_held);
            end else begin
              if (!(match && !has_second)) begin
                // Every held direction after the armed one re-arms in turn,
                // so the last one held ends up armed.
                repeat_valid_nxt     = 1'b1;
                repeat_dir_nxt       = last_held;
                next_repeat_time_nxt = now_plus_delay;
              end
              result.action = button_action;
            end
          end else begin
            repeat_valid_nxt = 1'b0;
            result.action    = button_action;
          end
        end
      end
      default: begin
      end
    endcase

    result.source = last_source_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_buttons_n_r   <= '1;
      repeat_valid_r     <= 1'b0;
      repeat_dir_r       <= '0;
      next_repeat_time_r <= '0;
      last_source_r      <= 1'b0;
    end else if (item_fire) begin
      prev_buttons_n_r   <= prev_buttons_n_nxt;
      repeat_valid_r     <= repeat_valid_nxt;
      repeat_dir_r       <= repeat_dir_nxt;
      next_repeat_time_r <= next_repeat_time_nxt;
      last_source_r      <= last_source_nxt;
    end
  end

endmodule

// File: rtl/button_action_autorepeat.sv
// Top level of the button navigation block: stream ports, configuration
// registers, input and result registers. Depends on bnav_pkg and bnav_core.

// Turns timestamped, active-low button samples into navigation actions with
// edge detection and directional autorepeat. An item on the input stream is a
// button sample, a mouse-activity note or a resync of the edge history (tuser
// selects which); only button samples give a result, exactly one each,
// carrying the action and the current input source. Action priority is home,
// then a newly pressed direction (which arms repeat after press_delay_ms),
// then repeat of a held direction every repeat_period_ms, then confirm and back
// edges. Times compare as a wrap-safe signed 32-bit difference, so now_ms may
// wrap freely. Every item is held in the input register and, if it gives a
// result, moves on into the result register once that register is free; the
// block takes one item per cycle while the result register is free or being
// drained. The rate is set by the single pass through the decision logic,
// whose state feeds the next item. Configuration is written through the cfg
// port (index 0 initial delay, index 1 repeat period); the user must write it
// only while no item is in flight, as the block does not enforce this. The
// port is always ready.
module button_action_autorepeat (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [39:0]                           in_tdata,  // buttons_n[6:0], system_home[7], now_ms[39:8]
  input  logic [bnav_pkg::KindW-1:0]            in_tuser,  // kind[1:0]
  // Result stream.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata, // action[2:0], source[3], zero[7:4]
  // Configuration write port.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bnav_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [bnav_pkg::DelayW-1:0]           cfg_data
);
  import bnav_pkg::*;

  cfg_t    cfg_r;
  item_t   s1_item_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  logic [ActionW-1:0] out_action_r;
  logic    out_source_r;

  result_t result;
  logic    out_free;
  logic    s1_advance;

  // The item in the input register moves on when it gives no result, or when
  // the result register is empty or being emptied this cycle.
  assign out_free   = !out_valid_r || out_tready;
  assign s1_advance = s1_valid_r && (!result.has_result || out_free);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_delay_ms   <= InitialDelayReset;
      cfg_r.repeat_period_ms <= RepeatPeriodReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INITIAL_DELAY: cfg_r.press_delay_ms   <= cfg_data;
        CFG_REPEAT_PERIOD: cfg_r.repeat_period_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.kind        <= in_tuser;
      s1_item_r.buttons_n   <= in_tdata[ButtonsW-1:0];
      s1_item_r.system_home <= in_tdata[ButtonsW];
      s1_item_r.now_ms      <= in_tdata[ButtonsW+TimeW:ButtonsW+1];
    end
  end

  bnav_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (s1_advance),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .result    (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_advance && result.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_advance && result.has_result) begin
      out_action_r <= result.action;
      out_source_r <= result.source;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_source_r, out_action_r};

endmodule
